// ===== design/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types, constants and helpers for the stroke line rasterizer.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int COORD_W = 7;
  localparam int CFG_W   = 6;
  localparam int ERR_W   = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic signed [COORD_W-1:0] COORD_LOW  = -7'sd16;
  localparam logic signed [COORD_W-1:0] COORD_HIGH = 7'sd47;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] CANVAS_RESET = 6'd32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0]        delta_t;
  typedef logic signed [ERR_W-1:0]   err_t;

  // Walk position and error term of the line stepper.
  typedef struct packed {
    coord_t x;
    coord_t y;
    err_t   err;
  } walk_t;

  // Constant line setup shared by every step.
  typedef struct packed {
    delta_t dx;
    delta_t dy;
    logic   sx_neg;
    logic   sy_neg;
  } line_t;

  function automatic coord_t sat_coord(input coord_t v);
    coord_t r;
    if (v < COORD_LOW) begin
      r = COORD_LOW;
    end else if (v > COORD_HIGH) begin
      r = COORD_HIGH;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/stroke_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// stroke_line_rasterizer
// Pointer samples to pixel writes along a Bresenham line, one point a beat.
// ----------------------------------------------------------------------------
// Flow: a sample loads the line setup and walk registers; up to 64 points
//   per line are registered out. The shared step unit advances one point per
//   cycle when the output is not stalled; in_ready is low until the last point.
// Reset: synchronous active low; no stroke, previous point 0, canvas 32x32.
// ----------------------------------------------------------------------------
module stroke_line_rasterizer
  import slr_pkg::*;
#(
  parameter int MAX_CANVAS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [6:0]    in_cell_x,
  input  logic signed [6:0]    in_cell_y,
  input  logic                 in_left_button,
  input  logic                 in_right_button,
  input  logic                 in_console_open,
  input  logic                 in_clear_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [6:0]    out_point_x,
  output logic signed [6:0]    out_point_y,
  output logic                 out_pixel_value,
  output logic                 out_write_enable,
  output logic                 out_clear_canvas,
  output logic                 out_last_point
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic             state_r;
  logic             stroke_r;
  coord_t           prev_x_r;
  coord_t           prev_y_r;
  logic [CFG_W-1:0] cfg_w_r;
  logic [CFG_W-1:0] cfg_h_r;
  walk_t            walk_r;
  line_t            line_r;
  coord_t           tgt_x_r;
  coord_t           tgt_y_r;
  logic             val_r;
  logic             clr_r;
  logic             out_valid_r;
  coord_t           out_x_r;
  coord_t           out_y_r;
  logic             out_val_r;
  logic             out_we_r;
  logic             out_clr_r;
  logic             out_last_r;

  logic             in_acc;
  coord_t           cx;
  coord_t           cy;
  logic             any_btn;
  logic signed [COORD_W:0] diff_x;
  logic signed [COORD_W:0] diff_y;
  delta_t           dx;
  delta_t           dy;
  walk_t            walk_nxt;
  logic             in_canvas;
  logic             out_free;
  logic             emit;
  logic             at_end;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign cx       = sat_coord(in_cell_x);
  assign cy       = sat_coord(in_cell_y);
  assign any_btn  = in_left_button || in_right_button;
  assign diff_x   = {cx[COORD_W-1], cx} - {prev_x_r[COORD_W-1], prev_x_r};
  assign diff_y   = {cy[COORD_W-1], cy} - {prev_y_r[COORD_W-1], prev_y_r};
  assign dx       = diff_x[COORD_W] ? delta_t'(-diff_x) : diff_x[COORD_W-1:0];
  assign dy       = diff_y[COORD_W] ? delta_t'(-diff_y) : diff_y[COORD_W-1:0];

  assign out_free = !out_valid_r || out_ready;
  assign emit     = (state_r == ST_WALK) && out_free;
  assign at_end   = clr_r || ((walk_r.x == tgt_x_r) && (walk_r.y == tgt_y_r));

  slr_step u_step (
    .cur  (walk_r),
    .line (line_r),
    .nxt  (walk_nxt)
  );

  slr_inside #(
    .MAX_CANVAS (MAX_CANVAS)
  ) u_inside (
    .canvas_width  (cfg_w_r),
    .canvas_height (cfg_h_r),
    .x             (walk_r.x),
    .y             (walk_r.y),
    .in_canvas     (in_canvas)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stroke_r    <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      cfg_w_r     <= CANVAS_RESET;
      cfg_h_r     <= CANVAS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CANVAS_WIDTH:  cfg_w_r <= cfg_wdata;
          CFG_CANVAS_HEIGHT: cfg_h_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_console_open) begin
              stroke_r <= 1'b0;
            end else if (!any_btn) begin
              stroke_r <= 1'b0;
              if (in_clear_key) begin
                state_r <= ST_WALK;
              end
            end else begin
              stroke_r <= 1'b1;
              prev_x_r <= cx;
              prev_y_r <= cy;
              state_r  <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (emit && at_end) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // line setup and walk
  always_ff @(posedge clk) begin
    if (in_acc) begin
      clr_r         <= !any_btn;
      val_r         <= in_right_button;
      tgt_x_r       <= cx;
      tgt_y_r       <= cy;
      line_r.dx     <= dx;
      line_r.dy     <= dy;
      line_r.sx_neg <= !(prev_x_r < cx);
      line_r.sy_neg <= !(prev_y_r < cy);
      walk_r.err    <= $signed({2'b00, dx}) - $signed({2'b00, dy});
      if (stroke_r) begin
        walk_r.x <= prev_x_r;
        walk_r.y <= prev_y_r;
      end else begin
        walk_r.x <= cx;
        walk_r.y <= cy;
      end
    end else if (emit && !at_end) begin
      walk_r <= walk_nxt;
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r    <= clr_r ? '0 : walk_r.x;
      out_y_r    <= clr_r ? '0 : walk_r.y;
      out_val_r  <= !clr_r && val_r;
      out_we_r   <= !clr_r && in_canvas;
      out_clr_r  <= clr_r;
      out_last_r <= at_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_x      = out_x_r;
  assign out_point_y      = out_y_r;
  assign out_pixel_value  = out_val_r;
  assign out_write_enable = out_we_r;
  assign out_clear_canvas = out_clr_r;
  assign out_last_point   = out_last_r;

endmodule

// ===== design/slr_step.sv =====
// ----------------------------------------------------------------------------
// slr_step
// One Bresenham step: error test, coordinate advance and error update.
// ----------------------------------------------------------------------------
module slr_step
  import slr_pkg::*;
(
  input  walk_t cur,
  input  line_t line,
  output walk_t nxt
);

  logic signed [ERR_W:0] e2;
  logic signed [ERR_W:0] dx_s;
  logic signed [ERR_W:0] dy_s;
  logic                  step_x;
  logic                  step_y;
  err_t                  dx_e;
  err_t                  dy_e;

  assign e2     = {cur.err, 1'b0};
  assign dx_s   = $signed({{(ERR_W+1-COORD_W){1'b0}}, line.dx});
  assign dy_s   = $signed({{(ERR_W+1-COORD_W){1'b0}}, line.dy});
  assign step_x = e2 > -dy_s;
  assign step_y = e2 < dx_s;
  assign dx_e   = $signed({{(ERR_W-COORD_W){1'b0}}, line.dx});
  assign dy_e   = $signed({{(ERR_W-COORD_W){1'b0}}, line.dy});

  always_comb begin
    nxt = cur;
    if (step_x) begin
      nxt.x = line.sx_neg ? cur.x - 7'sd1 : cur.x + 7'sd1;
    end
    if (step_y) begin
      nxt.y = line.sy_neg ? cur.y - 7'sd1 : cur.y + 7'sd1;
    end
    nxt.err = cur.err - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
  end

endmodule

// ===== design/slr_inside.sv =====
// ----------------------------------------------------------------------------
// slr_inside
// Canvas bounds check with the size registers clipped to MAX_CANVAS.
// ----------------------------------------------------------------------------
module slr_inside
  import slr_pkg::*;
#(
  parameter int MAX_CANVAS = 32
) (
  input  logic [CFG_W-1:0] canvas_width,
  input  logic [CFG_W-1:0] canvas_height,
  input  coord_t           x,
  input  coord_t           y,
  output logic             in_canvas
);

  localparam int MW = $clog2(MAX_CANVAS + 1);
  localparam int SW = (MW > CFG_W) ? MW : CFG_W;
  localparam logic [SW-1:0] MAX_S = SW'(MAX_CANVAS);

  logic [SW-1:0] w_ext;
  logic [SW-1:0] h_ext;
  logic [SW-1:0] w_eff;
  logic [SW-1:0] h_eff;
  logic [SW-1:0] x_ext;
  logic [SW-1:0] y_ext;

  assign w_ext = SW'(canvas_width);
  assign h_ext = SW'(canvas_height);
  assign w_eff = (w_ext > MAX_S) ? MAX_S : w_ext;
  assign h_eff = (h_ext > MAX_S) ? MAX_S : h_ext;
  assign x_ext = SW'(x[COORD_W-2:0]);
  assign y_ext = SW'(y[COORD_W-2:0]);

  assign in_canvas = !x[COORD_W-1] && !y[COORD_W-1] && (x_ext < w_eff) && (y_ext < h_eff);

endmodule

// ===== bench/slr_point_checker.sv =====
// ----------------------------------------------------------------------------
// slr_point_checker
// Watches the sample, result and register ports of the stroke line
// rasterizer. It predicts the point beats of every accepted sample with its
// own line walker and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module slr_point_checker
  import slr_pkg::*;
#(
  parameter int MAX_CANVAS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [6:0]    in_cell_x,
  input  logic signed [6:0]    in_cell_y,
  input  logic                 in_left_button,
  input  logic                 in_right_button,
  input  logic                 in_console_open,
  input  logic                 in_clear_key,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [6:0]    out_point_x,
  input  logic signed [6:0]    out_point_y,
  input  logic                 out_pixel_value,
  input  logic                 out_write_enable,
  input  logic                 out_clear_canvas,
  input  logic                 out_last_point,
  output int                   fail_count,
  output int                   pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   value;
    logic   write;
    logic   clear;
    logic   last;
  } point_beat_t;

  point_beat_t   awaited_points[$];
  logic [CFG_W-1:0] canvas_w = CANVAS_RESET;
  logic [CFG_W-1:0] canvas_h = CANVAS_RESET;
  bit            stroke_on = 1'b0;
  int            pen_x = 0;
  int            pen_y = 0;
  int            mismatches = 0;
  int            beat_count = 0;

  assign fail_count = mismatches;

  function automatic int clamp_cell(input logic [6:0] raw);
    int v;
    v = int'($signed(raw));
    if (v < -16) v = -16;
    if (v > 47) v = 47;
    return v;
  endfunction

  function automatic logic on_canvas(input int x, input int y);
    int w;
    int h;
    w = (canvas_w > MAX_CANVAS) ? MAX_CANVAS : int'(canvas_w);
    h = (canvas_h > MAX_CANVAS) ? MAX_CANVAS : int'(canvas_h);
    return (x >= 0 && y >= 0 && x < w && y < h);
  endfunction

  task automatic add_point(input int x, input int y, input logic value);
    point_beat_t p;
    p.x     = coord_t'(x);
    p.y     = coord_t'(y);
    p.value = value;
    p.write = on_canvas(x, y);
    p.clear = 1'b0;
    p.last  = 1'b0;
    awaited_points.push_back(p);
  endtask

  task automatic predict_sample();
    int cx, cy, x, y, dx, dy, sx, sy, err, e2, n;
    logic value;
    point_beat_t p;
    cx = clamp_cell(in_cell_x);
    cy = clamp_cell(in_cell_y);
    if (in_console_open) begin
      stroke_on = 1'b0;
    end else if (!in_left_button && !in_right_button) begin
      stroke_on = 1'b0;
      if (in_clear_key) begin
        p = '{x: '0, y: '0, value: 1'b0, write: 1'b0, clear: 1'b1, last: 1'b1};
        awaited_points.push_back(p);
      end
    end else begin
      value = in_right_button;
      if (stroke_on) begin
        x   = pen_x;
        y   = pen_y;
        dx  = (cx > x) ? cx - x : x - cx;
        dy  = (cy > y) ? cy - y : y - cy;
        sx  = (x < cx) ? 1 : -1;
        sy  = (y < cy) ? 1 : -1;
        err = dx - dy;
        n   = 0;
        while (n < 64) begin
          add_point(x, y, value);
          n++;
          if (x == cx && y == cy) break;
          e2 = 2 * err;
          if (e2 > -dy) begin
            err -= dy;
            x += sx;
          end
          if (e2 < dx) begin
            err += dx;
            y += sy;
          end
        end
      end else begin
        add_point(cx, cy, value);
      end
      awaited_points[awaited_points.size()-1].last = 1'b1;
      stroke_on = 1'b1;
      pen_x = cx;
      pen_y = cy;
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: beat %0d %s got %0d want %0d", $realtime, beat_count, field, got, want);
    mismatches++;
  endtask

  task automatic check_beat();
    point_beat_t p;
    if (awaited_points.size() == 0) begin
      report_mismatch("unexpected beat, x", int'(out_point_x), 0);
    end else begin
      p = awaited_points.pop_front();
      if (out_point_x != p.x) report_mismatch("point_x", int'(out_point_x), int'(p.x));
      if (out_point_y != p.y) report_mismatch("point_y", int'(out_point_y), int'(p.y));
      if (out_pixel_value !== p.value)
        report_mismatch("pixel_value", int'(out_pixel_value), int'(p.value));
      if (out_write_enable !== p.write)
        report_mismatch("write_enable", int'(out_write_enable), int'(p.write));
      if (out_clear_canvas !== p.clear)
        report_mismatch("clear_canvas", int'(out_clear_canvas), int'(p.clear));
      if (out_last_point !== p.last)
        report_mismatch("last_point", int'(out_last_point), int'(p.last));
    end
    beat_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      canvas_w  = CANVAS_RESET;
      canvas_h  = CANVAS_RESET;
      stroke_on = 1'b0;
      pen_x     = 0;
      pen_y     = 0;
      awaited_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CANVAS_WIDTH:  canvas_w = cfg_wdata;
          CFG_CANVAS_HEIGHT: canvas_h = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_sample();
      if (out_valid && out_ready) check_beat();
    end
    pending <= awaited_points.size();
  end

endmodule

// ===== bench/stroke_line_rasterizer_test.sv =====
// ----------------------------------------------------------------------------
// stroke_line_rasterizer_test
// Drives pointer samples into the rasterizer: a directed set of strokes,
// clears and saturating coordinates, then random strokes under several
// canvas sizes, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module stroke_line_rasterizer_test;
  import slr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [6:0] x;
    logic [6:0] y;
    logic       l;
    logic       r;
    logic       con;
    logic       clr;
  } sample_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [6:0]    in_cell_x;
  logic signed [6:0]    in_cell_y;
  logic                 in_left_button;
  logic                 in_right_button;
  logic                 in_console_open;
  logic                 in_clear_key;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [6:0]    out_point_x;
  logic signed [6:0]    out_point_y;
  logic                 out_pixel_value;
  logic                 out_write_enable;
  logic                 out_clear_canvas;
  logic                 out_last_point;
  int                   fail_count;
  int                   pending;

  int pen_x = 0;
  int pen_y = 0;
  int stroke_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  stroke_line_rasterizer uut (.*);

  slr_point_checker #(.MAX_CANVAS(32)) point_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: runs of always-ready, mostly-ready and mostly-stalled
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(30, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic sample_t mk(input int x, input int y, input bit l, input bit r,
                                 input bit con, input bit clr);
    sample_t s;
    s.x = 7'(x);
    s.y = 7'(y);
    s.l = l;
    s.r = r;
    s.con = con;
    s.clr = clr;
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    in_valid        <= 1'b1;
    in_cell_x       <= s.x;
    in_cell_y       <= s.y;
    in_left_button  <= s.l;
    in_right_button <= s.r;
    in_console_open <= s.con;
    in_clear_key    <= s.clr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_canvas(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    drain();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CANVAS_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_CANVAS_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t next_sample();
    sample_t s;
    int kind;
    kind  = $urandom_range(0, 99);
    s.x   = 7'($urandom_range(0, 127));
    s.y   = 7'($urandom_range(0, 127));
    s.l   = 1'b0;
    s.r   = 1'b0;
    s.con = 1'b0;
    s.clr = 1'($urandom_range(0, 1));
    if (kind < 72) begin
      if (stroke_left == 0 || $urandom_range(0, 5) == 0) begin
        if (stroke_left == 0) stroke_left = $urandom_range(2, 12);
        pen_x = $urandom_range(0, 63) - 16;
        pen_y = $urandom_range(0, 63) - 16;
      end else begin
        pen_x = pen_x + $urandom_range(0, 8) - 4;
        pen_y = pen_y + $urandom_range(0, 8) - 4;
        if (pen_x < -16) pen_x = -16;
        if (pen_x > 47) pen_x = 47;
        if (pen_y < -16) pen_y = -16;
        if (pen_y > 47) pen_y = 47;
      end
      stroke_left--;
      {s.l, s.r} = 2'($urandom_range(1, 3));
      s.x = 7'(pen_x);
      s.y = 7'(pen_y);
    end else if (kind < 80) begin
      stroke_left = 0;
      s.clr = 1'b0;
    end else if (kind < 88) begin
      stroke_left = 0;
      s.clr = 1'b1;
    end else if (kind < 94) begin
      stroke_left = 0;
      s.con = 1'b1;
      {s.l, s.r} = 2'($urandom_range(0, 3));
    end else begin
      {s.l, s.r} = 2'($urandom_range(1, 3));
    end
    return s;
  endfunction

  task automatic random_phase(input int target);
    int made;
    int burst;
    int k;
    sample_t s;
    made = 0;
    while (made < target) begin
      burst = $urandom_range(1, 10);
      for (k = 0; k < burst && made < target; k++) begin
        s = next_sample();
        made++;
        send_sample(s);
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_CANVAS_WIDTH;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_cell_x       <= '0;
    in_cell_y       <= '0;
    in_left_button  <= 1'b0;
    in_right_button <= 1'b0;
    in_console_open <= 1'b0;
    in_clear_key    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strokes on the 32x32 reset canvas
    send_sample(mk(0, 0, 0, 0, 0, 0));
    send_sample(mk(9, 9, 0, 0, 0, 1));
    send_sample(mk(0, 0, 1, 0, 0, 0));
    send_sample(mk(31, 31, 1, 0, 0, 0));
    send_sample(mk(47, -16, 1, 1, 0, 0));
    send_sample(mk(-64, 63, 0, 1, 0, 1));
    send_sample(mk(-16, 47, 0, 1, 0, 0));
    send_sample(mk(20, 20, 1, 0, 1, 0));
    send_sample(mk(5, 5, 0, 1, 0, 0));
    send_sample(mk(40, 5, 0, 1, 0, 0));
    send_sample(mk(40, -10, 1, 0, 0, 0));
    send_sample(mk(-3, 2, 1, 0, 0, 0));
    send_sample(mk(0, 0, 0, 0, 1, 1));
    send_sample(mk(63, -64, 1, 0, 0, 0));
    send_sample(mk(-1, 32, 1, 0, 0, 0));
    send_sample(mk(31, 0, 1, 0, 0, 0));
    send_sample(mk(32, 31, 1, 0, 0, 0));
    send_sample(mk(0, 0, 0, 0, 0, 1));
    send_sample(mk(10, -16, 0, 1, 0, 0));
    send_sample(mk(3, 47, 0, 1, 0, 0));
    send_sample(mk(-5, 0, 0, 0, 0, 0));
    random_phase(65);

    set_canvas(6'd1, 6'd32);
    random_phase(65);
    set_canvas(6'd0, 6'd63);
    random_phase(65);
    set_canvas(6'd63, 6'd0);
    random_phase(65);
    set_canvas(6'd33, 6'd1);
    random_phase(65);
    set_canvas(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    random_phase(65);

    drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(10ms);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
design/slr_pkg.sv
design/slr_step.sv
design/slr_inside.sv
design/stroke_line_rasterizer.sv
bench/slr_point_checker.sv
bench/stroke_line_rasterizer_test.sv
